@@ src/running_median_two_heaps_macros.svh @@
// Assertion macros shared by the running median block.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define RMH_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("running median check failed");

// Next-cycle implication.
`define RMH_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("running median check failed");

`endif

@@ src/rmh_pkg.sv @@
// ----------------------------------------------------------------------------
// rmh_pkg
// Widths of the running median payload fields.
// ----------------------------------------------------------------------------
package rmh_pkg;
	localparam int SAMPLE_W = 32;
	localparam int MEDIAN_W = 33;
	localparam int COUNT_W  = 11;
endpackage

@@ src/rmh_ram.sv @@
// ----------------------------------------------------------------------------
// rmh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 514
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ src/running_median_two_heaps.sv @@
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median over a stream of signed samples kept in a max-heap and a
// min-heap, with one shared compare unit stepping the heap sifts.
// ----------------------------------------------------------------------------
// Each item offers one sample, added unless the store is full, and yields one
// result: twice the median and the number of samples held. A rejected sample
// goes straight to the result. The work for an accepted sample is an insert
// sift-up, then at most one pop sift-down and one more sift-up for
// rebalancing, each step a heap RAM read followed by one compare. The input
// is taken again in the cycle after the result is registered. A new item is
// taken while the previous result still waits at the output, but its own
// result waits until that one has left.
// Heap RAMs need no clearing; only their size counters are reset.
module running_median_two_heaps #(
	parameter int CAPACITY = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [rmh_pkg::SAMPLE_W-1:0]  sample,
	input  logic                          restart_stream,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [rmh_pkg::MEDIAN_W-1:0]  median_doubled,
	output logic [rmh_pkg::COUNT_W-1:0]   sample_count,
	output logic                          accepted
);
	`include "running_median_two_heaps_macros.svh"

	localparam int DEPTH = CAPACITY / 2 + 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(CAPACITY + 1);
	localparam int W     = rmh_pkg::SAMPLE_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ROUTE, ST_UP_CHK, ST_UP_CMP, ST_BAL, ST_DN_LOAD,
		ST_DN_CHK, ST_DN_L, ST_DN_R, ST_DN_CMP, ST_POP_END, ST_RESULT
	} state_t;

	state_t         state_q;
	logic [SW-1:0]  lsz_q, usz_q;
	logic           sel_q;       // 0: lower max-heap, 1: upper min-heap
	logic [AW-1:0]  i_q, cidx_q;
	logic [W-1:0]   v_q, x_q, cval_q, ltop_q, utop_q;
	logic           acc_q;

	logic           we;
	logic [AW-1:0]  waddr, raddr;
	logic [W-1:0]   wdata, lo_rd, up_rd, rdata;
	logic [W-1:0]   cmp_a, cmp_b;
	logic           cmp_max, cmp_hit;
	logic [31:0]    cur_size, l32, tot32;
	logic           bal_lower, bal_upper;

	rmh_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_lower (
		.clk(clk), .we(we && !sel_q), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(lo_rd)
	);
	rmh_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_upper (
		.clk(clk), .we(we && sel_q), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(up_rd)
	);

	assign rdata        = sel_q ? up_rd : lo_rd;
	assign sample_stall = (state_q != ST_IDLE);
	assign cur_size     = sel_q ? 32'(usz_q) : 32'(lsz_q);
	assign l32          = 32'({i_q, 1'b1});
	assign tot32        = 32'(lsz_q) + 32'(usz_q);
	assign bal_lower    = 32'(lsz_q) > 32'(usz_q) + 32'd1;
	assign bal_upper    = 32'(lsz_q) + 32'd1 < 32'(usz_q);

	// The one compare unit: "a ranks above b" in the selected heap order, or a < b when routing a sample.
	always_comb begin
		cmp_a   = cval_q;
		cmp_b   = x_q;
		cmp_max = !sel_q;
		unique case (state_q)
			ST_ROUTE: begin
				cmp_a   = v_q;
				cmp_b   = ltop_q;
				cmp_max = 1'b0;
			end
			ST_UP_CMP: begin
				cmp_a = v_q;
				cmp_b = rdata;
			end
			ST_DN_R: begin
				cmp_a = rdata;
				cmp_b = cval_q;
			end
			default: begin
			end
		endcase
		cmp_hit = cmp_max ? ($signed(cmp_a) > $signed(cmp_b))
		                  : ($signed(cmp_a) < $signed(cmp_b));
	end

	always_comb begin
		we    = 1'b0;
		waddr = i_q;
		wdata = v_q;
		raddr = AW'((32'(i_q) - 32'd1) >> 1);
		unique case (state_q)
			ST_UP_CHK: begin
				we = (i_q == '0);
			end
			ST_UP_CMP: begin
				we    = 1'b1;
				wdata = cmp_hit ? rdata : v_q;
			end
			ST_BAL: begin
				raddr = bal_lower ? AW'(lsz_q - SW'(1)) : AW'(usz_q - SW'(1));
			end
			ST_DN_CHK: begin
				we    = (l32 >= cur_size);
				wdata = x_q;
				raddr = AW'(l32);
			end
			ST_DN_L: begin
				raddr = AW'(l32 + 32'd1);
			end
			ST_DN_CMP: begin
				we    = 1'b1;
				wdata = cmp_hit ? cval_q : x_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			lsz_q          <= '0;
			usz_q          <= '0;
			result_valid   <= 1'b0;
			sel_q          <= 1'b0;
		end else begin
			if (we && waddr == '0) begin
				if (sel_q) begin
					utop_q <= wdata;
				end else begin
					ltop_q <= wdata;
				end
			end
			if (result_valid && !result_stall && state_q != ST_RESULT) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						v_q <= sample;
						if (restart_stream) begin
							lsz_q <= '0;
							usz_q <= '0;
						end
						state_q <= ST_ROUTE;
					end
				end
				ST_ROUTE: begin
					if (tot32 >= 32'(CAPACITY)) begin
						acc_q   <= 1'b0;
						state_q <= ST_RESULT;
					end else begin
						acc_q <= 1'b1;
						if (lsz_q == '0 || cmp_hit) begin
							sel_q <= 1'b0;
							i_q   <= AW'(lsz_q);
							lsz_q <= lsz_q + SW'(1);
						end else begin
							sel_q <= 1'b1;
							i_q   <= AW'(usz_q);
							usz_q <= usz_q + SW'(1);
						end
						state_q <= ST_UP_CHK;
					end
				end
				ST_UP_CHK: begin
					if (i_q == '0) begin
						state_q <= ST_BAL;
					end else begin
						state_q <= ST_UP_CMP;
					end
				end
				ST_UP_CMP: begin
					if (cmp_hit) begin
						i_q     <= raddr;
						state_q <= ST_UP_CHK;
					end else begin
						state_q <= ST_BAL;
					end
				end
				ST_BAL: begin
					// Pop the top of the larger heap; it is pushed to the other one.
					if (bal_lower) begin
						sel_q   <= 1'b0;
						v_q     <= ltop_q;
						lsz_q   <= lsz_q - SW'(1);
						state_q <= ST_DN_LOAD;
					end else if (bal_upper) begin
						sel_q   <= 1'b1;
						v_q     <= utop_q;
						usz_q   <= usz_q - SW'(1);
						state_q <= ST_DN_LOAD;
					end else begin
						state_q <= ST_RESULT;
					end
				end
				ST_DN_LOAD: begin
					x_q     <= rdata;
					i_q     <= '0;
					state_q <= ST_DN_CHK;
				end
				ST_DN_CHK: begin
					if (l32 >= cur_size) begin
						state_q <= ST_POP_END;
					end else begin
						cidx_q  <= AW'(l32);
						state_q <= ST_DN_L;
					end
				end
				ST_DN_L: begin
					cval_q <= rdata;
					if (l32 + 32'd1 < cur_size) begin
						state_q <= ST_DN_R;
					end else begin
						state_q <= ST_DN_CMP;
					end
				end
				ST_DN_R: begin
					if (cmp_hit) begin
						cval_q <= rdata;
						cidx_q <= AW'(l32 + 32'd1);
					end
					state_q <= ST_DN_CMP;
				end
				ST_DN_CMP: begin
					if (cmp_hit) begin
						i_q     <= cidx_q;
						state_q <= ST_DN_CHK;
					end else begin
						state_q <= ST_POP_END;
					end
				end
				ST_POP_END: begin
					sel_q <= !sel_q;
					if (sel_q) begin
						i_q   <= AW'(lsz_q);
						lsz_q <= lsz_q + SW'(1);
					end else begin
						i_q   <= AW'(usz_q);
						usz_q <= usz_q + SW'(1);
					end
					state_q <= ST_UP_CHK;
				end
				ST_RESULT: begin
					if (!result_valid || !result_stall) begin
						result_valid <= 1'b1;
						accepted     <= acc_q;
						sample_count <= tot32[rmh_pkg::COUNT_W-1:0];
						if (lsz_q == usz_q) begin
							median_doubled <= (lsz_q == '0) ? '0 :
								{ltop_q[W-1], ltop_q} + {utop_q[W-1], utop_q};
						end else if (usz_q > lsz_q) begin
							median_doubled <= {utop_q, 1'b0};
						end else begin
							median_doubled <= {ltop_q, 1'b0};
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RMH_ASSERT_NEXT(a_take_routes, clk, arst_n, sample_valid && !sample_stall, state_q == ST_ROUTE)
	`RMH_ASSERT_IMPLY(a_idle_balanced, clk, arst_n, state_q == ST_IDLE, !bal_lower && !bal_upper)
	`RMH_ASSERT_IMPLY(a_idle_in_capacity, clk, arst_n, state_q == ST_IDLE, tot32 <= 32'(CAPACITY))
endmodule
